// File: rtl/vvfe_pkg.sv
package vvfe_pkg;

	// Default edge length of the voxel cube.
	localparam int SIDE_DEF = 16;

	// Number of commands held between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	localparam int COORD_W = 4;
	localparam int KIND_W  = 8;

	// Command codes carried through the queue.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MESH  = 1'b1;

	// One classified command: coordinates are already known to lie inside the cube.
	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [KIND_W-1:0]  kind;
	} cmd_t;

endpackage

// File: rtl/vvfe_queue.sv
module vvfe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vvfe_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output vvfe_pkg::cmd_t head,
	output logic          empty
);
	import vvfe_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/vvfe_front.sv
module vvfe_front #(
	parameter int SIDE = vvfe_pkg::SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         req_type,
	input  logic [vvfe_pkg::COORD_W-1:0] voxel_x,
	input  logic [vvfe_pkg::COORD_W-1:0] voxel_y,
	input  logic [vvfe_pkg::COORD_W-1:0] voxel_z,
	input  logic [vvfe_pkg::KIND_W-1:0]  kind_in,
	input  logic                         clear_busy,
	input  logic                         queue_full,
	output logic                         push,
	output vvfe_pkg::cmd_t               push_cmd
);
	import vvfe_pkg::*;

	localparam logic [6:0] SIDE_W = 7'(SIDE);

	logic accept;
	logic in_cube;
	logic vld_q;
	cmd_t cmd_q;

	// Words with a coordinate outside the cube are dropped here.
	assign in_cube = ({3'b000, voxel_x} < SIDE_W) && ({3'b000, voxel_y} < SIDE_W) &&
		({3'b000, voxel_z} < SIDE_W);

	assign req_stall = clear_busy || (vld_q && queue_full);
	assign accept    = req_valid && !req_stall;
	assign push      = vld_q && !queue_full;
	assign push_cmd  = cmd_q;

	// Holding register for one classified command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= in_cube;
		end else if (push) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op   <= req_type ? OP_MESH : OP_WRITE;
			cmd_q.x    <= voxel_x;
			cmd_q.y    <= voxel_y;
			cmd_q.z    <= voxel_z;
			cmd_q.kind <= kind_in;
		end
	end

endmodule

// File: rtl/vvfe_back.sv
module vvfe_back #(
	parameter int SIDE = vvfe_pkg::SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         queue_empty,
	input  vvfe_pkg::cmd_t               head,
	output logic                         pop,
	output logic                         clear_busy,
	output logic                         face_valid,
	input  logic                         face_stall,
	output logic [vvfe_pkg::COORD_W-1:0] face_x,
	output logic [vvfe_pkg::COORD_W-1:0] face_y,
	output logic [vvfe_pkg::COORD_W-1:0] face_z,
	output logic [2:0]                   face_dir,
	output logic [vvfe_pkg::KIND_W-1:0]  face_kind,
	output logic                         last_face
);
	import vvfe_pkg::*;

	localparam int ACW   = $clog2(SIDE);
	localparam int AW    = 3 * ACW;
	localparam int DEPTH = 2 ** AW;
	localparam logic [ACW-1:0] CMAX = ACW'(SIDE - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	// Read step codes: the owning voxel first, then the six neighbors in face order.
	localparam logic [2:0] RD_SELF = 3'd0;
	localparam logic [2:0] RD_YP   = 3'd1;
	localparam logic [2:0] RD_YM   = 3'd2;
	localparam logic [2:0] RD_ZP   = 3'd3;
	localparam logic [2:0] RD_ZM   = 3'd4;
	localparam logic [2:0] RD_XP   = 3'd5;
	localparam logic [2:0] RD_XM   = 3'd6;

	logic [KIND_W-1:0] mem [DEPTH];

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_cnt_q;
	logic [2:0]        idx_q;
	cmd_t              cmd_q;
	logic              ph_vld_s1;
	logic [2:0]        ph_idx_s1;
	logic              ph_edge_s1;
	logic [KIND_W-1:0] rd_s1;
	logic [KIND_W-1:0] kind_q;
	logic [5:0]        mask_q;
	logic              face_valid_q;

	logic [ACW-1:0] cx, cy, cz;
	logic [ACW-1:0] nx, ny, nz;
	logic           edge_hit;
	logic [AW-1:0]  raddr;
	logic [AW-1:0]  waddr;
	logic [2:0]     sel_dir;
	logic [5:0]     sel_oh;
	logic           sel_last;
	logic           load;

	assign clear_busy = (state_q == S_CLEAR);
	assign pop        = (state_q == S_IDLE) && !queue_empty;
	assign waddr      = {ACW'(head.z), ACW'(head.y), ACW'(head.x)};

	// Neighbor address for the current read step; a neighbor off the cube is air.
	always_comb begin
		cx       = ACW'(cmd_q.x);
		cy       = ACW'(cmd_q.y);
		cz       = ACW'(cmd_q.z);
		nx       = cx;
		ny       = cy;
		nz       = cz;
		edge_hit = 1'b0;
		unique case (idx_q)
			RD_YP: begin
				ny       = cy + ACW'(1);
				edge_hit = (cy == CMAX);
			end
			RD_YM: begin
				ny       = cy - ACW'(1);
				edge_hit = (cy == '0);
			end
			RD_ZP: begin
				nz       = cz + ACW'(1);
				edge_hit = (cz == CMAX);
			end
			RD_ZM: begin
				nz       = cz - ACW'(1);
				edge_hit = (cz == '0);
			end
			RD_XP: begin
				nx       = cx + ACW'(1);
				edge_hit = (cx == CMAX);
			end
			RD_XM: begin
				nx       = cx - ACW'(1);
				edge_hit = (cx == '0);
			end
			default: begin
				edge_hit = 1'b0;
			end
		endcase
		raddr = {nz, ny, nx};
	end

	// Lowest pending face goes out next; it is the last one when nothing else is pending.
	always_comb begin
		sel_dir = 3'd0;
		for (int i = 5; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel_dir = 3'(i);
			end
		end
		sel_oh   = 6'b000001 << sel_dir;
		sel_last = ((mask_q & ~sel_oh) == 6'b000000);
	end

	assign load = (state_q == S_EMIT) && (kind_q != '0) && (mask_q != 6'b000000) &&
		(!face_valid_q || !face_stall);

	// Voxel memory: one write port shared by the clearing pass and voxel writes.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mem[clr_cnt_q] <= '0;
		end else if (pop && head.op == OP_WRITE) begin
			mem[waddr] <= head.kind;
		end
		rd_s1 <= mem[raddr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			idx_q     <= RD_SELF;
			ph_vld_s1 <= 1'b0;
		end else begin
			ph_vld_s1 <= (state_q == S_READ);
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop && head.op == OP_MESH) begin
						state_q <= S_READ;
						idx_q   <= RD_SELF;
					end
				end
				S_READ: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == RD_XM) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (kind_q == '0 || mask_q == 6'b000000) begin
						state_q <= S_IDLE;
					end else if (load && sel_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Read results: the owning voxel's kind, then one visibility bit per face.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		ph_idx_s1  <= idx_q;
		ph_edge_s1 <= edge_hit;
		if (ph_vld_s1) begin
			if (ph_idx_s1 == RD_SELF) begin
				kind_q <= rd_s1;
			end else begin
				mask_q[3'(ph_idx_s1 - 3'd1)] <= ph_edge_s1 || (rd_s1 == '0);
			end
		end else if (load) begin
			mask_q <= mask_q & ~sel_oh;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_valid_q <= 1'b0;
		end else if (load) begin
			face_valid_q <= 1'b1;
		end else if (!face_stall) begin
			face_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			face_x    <= cmd_q.x;
			face_y    <= cmd_q.y;
			face_z    <= cmd_q.z;
			face_dir  <= sel_dir;
			face_kind <= kind_q;
			last_face <= sel_last;
		end
	end

	assign face_valid = face_valid_q;

	// An emitted face always belongs to a solid voxel.
	a_face_solid: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid_q |-> face_kind != '0)
		else $error("face emitted for an air voxel");

	// Nothing leaves the block while the memory is being cleared.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !face_valid_q)
		else $error("face emitted during the clearing pass");

	// Read data is only consumed for reads issued in the read phase.
	a_read_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ph_vld_s1 |-> $past(state_q) == S_READ)
		else $error("read result without a read step");

	// The final face of a burst returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && sel_last |=> state_q == S_IDLE)
		else $error("sequencer did not finish after the last face");

endmodule

// File: rtl/voxel_visible_face_extractor_unit.sv
// Voxel visible-face extractor.
// Request channel (req_valid / req_stall): a word with req_type 0 stores kind_in at
// (voxel_x, voxel_y, voxel_z) and gives no result; a word with req_type 1 asks for the
// visible faces of that voxel. Coordinates outside the cube are dropped.
// Face channel (face_valid / face_stall): one word per visible face of a solid voxel,
// in the order y+, y-, z+, z-, x+, x-, with last_face set on the final word. An air or
// fully enclosed voxel gives no word.
// Back end: a write is done as it is taken from the queue; a mesh request makes seven reads
// through the single voxel memory read port, then emits its faces, and the back end takes
// no new command until it is done with that request.
// A four-word command queue lets requests keep arriving while faces are emitted.
// Reset: the voxel memory is cleared to air one entry per cycle, all 2**(3*clog2(SIDE))
// entries (4096 for a side of 16); req_stall stays high for that pass.
// When face_stall is high the face word holds, the back end waits, and once the
// queue fills req_stall rises.
module voxel_visible_face_extractor_unit #(
	parameter int SIDE = vvfe_pkg::SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         req_type,
	input  logic [vvfe_pkg::COORD_W-1:0] voxel_x,
	input  logic [vvfe_pkg::COORD_W-1:0] voxel_y,
	input  logic [vvfe_pkg::COORD_W-1:0] voxel_z,
	input  logic [vvfe_pkg::KIND_W-1:0]  kind_in,
	output logic                         face_valid,
	input  logic                         face_stall,
	output logic [vvfe_pkg::COORD_W-1:0] face_x,
	output logic [vvfe_pkg::COORD_W-1:0] face_y,
	output logic [vvfe_pkg::COORD_W-1:0] face_z,
	output logic [2:0]                   face_dir,
	output logic [vvfe_pkg::KIND_W-1:0]  face_kind,
	output logic                         last_face
);
	import vvfe_pkg::*;

	logic clear_busy;
	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	// Front end: accepts and classifies request words.
	vvfe_front #(
		.SIDE(SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.voxel_x   (voxel_x),
		.voxel_y   (voxel_y),
		.voxel_z   (voxel_z),
		.kind_in   (kind_in),
		.clear_busy(clear_busy),
		.queue_full(queue_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Command queue between the two halves.
	vvfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (queue_full),
		.pop     (pop),
		.head    (head),
		.empty   (queue_empty)
	);

	// Back end: voxel memory, neighbor reads and face emission.
	vvfe_back #(
		.SIDE(SIDE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_empty(queue_empty),
		.head       (head),
		.pop        (pop),
		.clear_busy (clear_busy),
		.face_valid (face_valid),
		.face_stall (face_stall),
		.face_x     (face_x),
		.face_y     (face_y),
		.face_z     (face_z),
		.face_dir   (face_dir),
		.face_kind  (face_kind),
		.last_face  (last_face)
	);

endmodule

// File: sim/tb.sv
module tb;

	import vvfe_pkg::*;

	localparam int SIDE         = SIDE_DEF;
	localparam int NUM_DIRS     = 6;
	localparam int RANDOM_ITEMS = 260;
	localparam int IDLE_PCT     = 23;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	// Face directions in the order the block emits them.
	typedef enum logic [2:0] {
		FACE_UP   = 3'd0,
		FACE_DOWN = 3'd1,
		FACE_ZPOS = 3'd2,
		FACE_ZNEG = 3'd3,
		FACE_XPOS = 3'd4,
		FACE_XNEG = 3'd5
	} face_dir_e;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		face_dir_e          dir;
		logic [KIND_W-1:0]  kind;
		logic               last;
	} face_rec_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               req_type = OP_WRITE;
	logic [COORD_W-1:0] voxel_x = '0;
	logic [COORD_W-1:0] voxel_y = '0;
	logic [COORD_W-1:0] voxel_z = '0;
	logic [KIND_W-1:0]  kind_in = '0;
	logic               face_valid;
	logic               face_stall = 1'b0;
	logic [COORD_W-1:0] face_x;
	logic [COORD_W-1:0] face_y;
	logic [COORD_W-1:0] face_z;
	logic [2:0]         face_dir;
	logic [KIND_W-1:0]  face_kind;
	logic               last_face;

	// Shadow copy of the voxel store and the faces still owed by the block.
	logic [KIND_W-1:0]  voxel_kinds [SIDE*SIDE*SIDE];
	face_rec_t          pending_faces [$];

	int  mismatch_count = 0;
	int  cycle_count = 0;
	bit  steady = 1'b0;

	voxel_visible_face_extractor_unit #(
		.SIDE(SIDE)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.voxel_x    (voxel_x),
		.voxel_y    (voxel_y),
		.voxel_z    (voxel_z),
		.kind_in    (kind_in),
		.face_valid (face_valid),
		.face_stall (face_stall),
		.face_x     (face_x),
		.face_y     (face_y),
		.face_z     (face_z),
		.face_dir   (face_dir),
		.face_kind  (face_kind),
		.last_face  (last_face)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** voxel_visible_face_extractor_unit: FAILED **");
			$finish;
		end
	end

	function automatic bit in_cube(input int x, input int y, input int z);
		return x >= 0 && x < SIDE && y >= 0 && y < SIDE && z >= 0 && z < SIDE;
	endfunction

	function automatic int cell_index(input int x, input int y, input int z);
		return (z * SIDE + y) * SIDE + x;
	endfunction

	// Coordinates of the neighbor across one face; returns whether it lies in the cube.
	function automatic bit neighbor_of(input face_dir_e dir, input int x, input int y,
			input int z, output int nx, output int ny, output int nz);
		nx = x;
		ny = y;
		nz = z;
		case (dir)
			FACE_UP:   ny = y + 1;
			FACE_DOWN: ny = y - 1;
			FACE_ZPOS: nz = z + 1;
			FACE_ZNEG: nz = z - 1;
			FACE_XPOS: nx = x + 1;
			FACE_XNEG: nx = x - 1;
			default:   nx = -1;
		endcase
		return in_cube(nx, ny, nz);
	endfunction

	// Update the shadow store for a write, or queue the visible faces for a mesh request.
	function automatic void predict_request(input logic op, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
			input logic [KIND_W-1:0] kind);
		face_rec_t        burst [$];
		face_rec_t        rec;
		face_dir_e        dir;
		int               nx;
		int               ny;
		int               nz;
		logic [KIND_W-1:0] own;
		if (!in_cube(int'(x), int'(y), int'(z)))
			return;
		if (op == OP_WRITE) begin
			voxel_kinds[cell_index(int'(x), int'(y), int'(z))] = kind;
			return;
		end
		own = voxel_kinds[cell_index(int'(x), int'(y), int'(z))];
		if (own == '0)
			return;
		for (int d = 0; d < NUM_DIRS; d++) begin
			dir = face_dir_e'(d);
			if (!neighbor_of(dir, int'(x), int'(y), int'(z), nx, ny, nz) ||
					voxel_kinds[cell_index(nx, ny, nz)] == '0) begin
				rec.x    = x;
				rec.y    = y;
				rec.z    = z;
				rec.dir  = dir;
				rec.kind = own;
				rec.last = 1'b0;
				burst = {burst, rec};
			end
		end
		if (burst.size() != 0)
			burst[burst.size()-1].last = 1'b1;
		pending_faces = {pending_faces, burst};
	endfunction

	// Present one request word, hold it until taken, and predict its effect.
	task automatic send_word(input logic op, input int x, input int y, input int z,
			input int kind);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= op;
		voxel_x   <= COORD_W'(x);
		voxel_y   <= COORD_W'(y);
		voxel_z   <= COORD_W'(z);
		kind_in   <= KIND_W'(kind);
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_request(op, COORD_W'(x), COORD_W'(y), COORD_W'(z), KIND_W'(kind));
		@(negedge clk);
	endtask

	// The face side stalls at random except during the steady stretch.
	always @(negedge clk) begin
		face_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	task automatic check_field(input string name, input logic [KIND_W-1:0] want,
			input logic [KIND_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each accepted face word with the oldest expected face.
	always @(posedge clk) begin
		face_rec_t want;
		if (arst_n && face_valid === 1'b1 && !face_stall) begin
			if (pending_faces.size() == 0) begin
				$display("%0t: unexpected face word: expected none, actual x %0d y %0d z %0d dir %0d",
					$time, face_x, face_y, face_z, face_dir);
				mismatch_count++;
			end else begin
				want = pending_faces.pop_front();
				check_field("face_x", KIND_W'(want.x), KIND_W'(face_x));
				check_field("face_y", KIND_W'(want.y), KIND_W'(face_y));
				check_field("face_z", KIND_W'(want.z), KIND_W'(face_z));
				check_field("face_dir", KIND_W'(want.dir), KIND_W'(face_dir));
				check_field("face_kind", want.kind, face_kind);
				check_field("last_face", KIND_W'(want.last), KIND_W'(last_face));
			end
		end
	end

	// Meshing an empty store gives nothing, whatever kind_in carries.
	task automatic test_empty_store();
		send_word(OP_MESH, 0, 0, 0, 255);
		send_word(OP_MESH, SIDE-1, SIDE-1, SIDE-1, 0);
	endtask

	// Voxels on the cube boundary see outside neighbors as air.
	task automatic test_corner_voxels();
		send_word(OP_WRITE, 0, 0, 0, 255);
		send_word(OP_MESH, 0, 0, 0, 0);
		send_word(OP_WRITE, SIDE-1, SIDE-1, SIDE-1, 1);
		send_word(OP_MESH, SIDE-1, SIDE-1, SIDE-1, 255);
		send_word(OP_WRITE, SIDE-1, 0, SIDE-1, 8'h80);
		send_word(OP_WRITE, SIDE-1, 1, SIDE-1, 8'h7F);
		send_word(OP_MESH, SIDE-1, 0, SIDE-1, 8'h55);
		// Clearing a voxel back to air silences it.
		send_word(OP_WRITE, 0, 0, 0, 0);
		send_word(OP_MESH, 0, 0, 0, 8'hAA);
	endtask

	// A fully enclosed voxel shows no face until one neighbor is cleared.
	task automatic test_enclosed_voxel();
		int nx;
		int ny;
		int nz;
		send_word(OP_WRITE, 8, 7, 9, 8'hA5);
		for (int d = 0; d < NUM_DIRS; d++) begin
			void'(neighbor_of(face_dir_e'(d), 8, 7, 9, nx, ny, nz));
			send_word(OP_WRITE, nx, ny, nz, 8'h5A + d);
		end
		send_word(OP_MESH, 8, 7, 9, 0);
		void'(neighbor_of(FACE_XNEG, 8, 7, 9, nx, ny, nz));
		send_word(OP_WRITE, nx, ny, nz, 0);
		send_word(OP_MESH, 8, 7, 9, 8'hFF);
	endtask

	// Coordinates favor the boundary and a small crowded region so neighbors overlap.
	function automatic int pick_coord();
		int r;
		r = $urandom_range(9);
		if (r < 3)
			return $urandom_range(1) ? SIDE - 1 : 0;
		if (r < 7)
			return SIDE / 2 - 2 + $urandom_range(3);
		return $urandom_range(SIDE - 1);
	endfunction

	function automatic int pick_kind();
		return ($urandom_range(3) == 0) ? 0 : $urandom_range(255);
	endfunction

	// Mostly build-then-mesh scenes around a target voxel, with some stray words.
	task automatic test_random_scenes();
		int sent;
		int scene;
		int tx;
		int ty;
		int tz;
		int nx;
		int ny;
		int nz;
		int walls;
		sent  = 0;
		scene = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (scene >= 15 && scene < 30);
			tx = pick_coord();
			ty = pick_coord();
			tz = pick_coord();
			case ($urandom_range(9))
				0: begin
					send_word(OP_WRITE, tx, ty, tz, pick_kind());
					sent++;
				end
				1: begin
					send_word(OP_MESH, tx, ty, tz, $urandom_range(255));
					sent++;
				end
				default: begin
					walls = $urandom_range(NUM_DIRS);
					for (int i = 0; i < walls; i++) begin
						if (neighbor_of(face_dir_e'($urandom_range(NUM_DIRS - 1)), tx, ty, tz,
								nx, ny, nz)) begin
							send_word(OP_WRITE, nx, ny, nz, pick_kind());
							sent++;
						end
					end
					if ($urandom_range(99) < 85) begin
						send_word(OP_WRITE, tx, ty, tz,
							($urandom_range(9) == 0) ? 0 : $urandom_range(1, 255));
						sent++;
					end
					send_word(OP_MESH, tx, ty, tz, $urandom_range(255));
					sent++;
					if ($urandom_range(99) < 30 &&
							neighbor_of(face_dir_e'($urandom_range(NUM_DIRS - 1)), tx, ty, tz,
							nx, ny, nz)) begin
						send_word(OP_MESH, nx, ny, nz, $urandom_range(255));
						sent++;
					end
				end
			endcase
			scene++;
		end
		steady = 1'b0;
	endtask

	initial begin
		foreach (voxel_kinds[i])
			voxel_kinds[i] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_store();
		test_corner_voxels();
		test_enclosed_voxel();
		test_random_scenes();
		req_valid <= 1'b0;

		// Let the last bursts drain, then watch for stray words.
		while (pending_faces.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** voxel_visible_face_extractor_unit: PASSED **");
		else
			$display("** voxel_visible_face_extractor_unit: FAILED **");
		$finish;
	end

endmodule
